// ===== hdl/ctt_pkg.sv =====
// Shared types and constants for the callout timer table.
package ctt_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int TICK_BITS  = 32;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    localparam int MODE_W     = 3;
    localparam int HANDLE_W   = 16;
    localparam int TAG_W      = 16;
    localparam int DELAY_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int REM_W      = 32;
    localparam int IN_DATA_W  = HANDLE_W + TAG_W + DELAY_W;
    localparam int OUT_DATA_W = HANDLE_W + TAG_W + REM_W;
    localparam int OUT_USER_W = STATUS_W + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_ADD     = 3'd1,
        MODE_REMOVE  = 3'd2,
        MODE_RESET   = 3'd3,
        MODE_QUERY   = 3'd4,
        MODE_SERVICE = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NOMATCH = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    // One table entry as it sits in the slot memory.
    typedef struct packed {
        logic [HANDLE_W-1:0]  handle;
        logic [TAG_W-1:0]     tag;
        logic [TICK_BITS-1:0] deadline;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== hdl/ctt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/callout_timer_table_unit.sv =====
// Top level of the callout timer table: command sequencer, slot scan and result register.
//
// One command word enters on the s_axis channel: tuser carries the mode, tdata
// carries owner handle, event tag and delay. Every command answers with exactly
// one word on the m_axis channel: tuser carries status and the fired flag, tdata
// carries fired handle, fired tag and remaining ticks.
// Tick and the unused modes go from acceptance straight to the result step. Add, remove,
// reset, query and service scan the slots in index order through the registered read
// port of the slot memory, one slot per cycle, and stop at the first slot that
// qualifies; the result step follows the end of the scan.
// s_axis_tready is high only while the sequencer is idle; one command is in
// work at a time.
// The result sits in an output register, so the next command is accepted while
// it waits. If the receiver stalls, a finished command holds in its final step
// until the output register frees up, and no state changes before then.
// Reset clears the tick counter and marks every slot free; the slot memory is
// not cleared, since a slot is read only after add has written it.
module callout_timer_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // owner_handle [15:0], event_tag [31:16], delay_ticks [63:32]
    input  logic [ctt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // mode [2:0]
    input  logic [ctt_pkg::MODE_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // fired_handle [15:0], fired_tag [31:16], remaining_ticks [63:32]
    output logic [ctt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status [1:0], fired [2]
    output logic [ctt_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    import ctt_pkg::*;

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;

    logic [TICK_BITS-1:0] now_reg, now_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;

    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    slot_t                hit_slot_reg, hit_slot_next;

    logic                 out_vld_reg, out_vld_next;
    status_t              out_status_reg, out_status_next;
    logic                 out_fired_reg, out_fired_next;
    logic [HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    logic [TAG_W-1:0]     out_tag_reg, out_tag_next;
    logic [REM_W-1:0]     out_rem_reg, out_rem_next;

    logic                 ram_we;
    slot_t                ram_wslot;
    logic [SLOT_W-1:0]    ram_rdata;
    slot_t                rd_slot;
    logic                 slot_match;
    logic                 out_free;
    logic [TICK_BITS-1:0] new_deadline;

    ctt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (hit_idx_reg),
        .wdata (ram_wslot),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_slot       = slot_t'(ram_rdata);
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign new_deadline  = now_reg + TICK_BITS'(delay_reg);
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Qualifying test for the slot whose memory word has just come back.
    always_comb
    begin
        slot_match = 1'b0;
        case (mode_reg)
            MODE_ADD:
            begin
                slot_match = !active_reg[chk_idx_reg];
            end
            MODE_REMOVE, MODE_RESET, MODE_QUERY:
            begin
                slot_match = active_reg[chk_idx_reg] && (rd_slot.handle == handle_reg);
            end
            MODE_SERVICE:
            begin
                slot_match = active_reg[chk_idx_reg] && (rd_slot.deadline != '0)
                             && (now_reg >= rd_slot.deadline);
            end
            default:
            begin
                slot_match = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        handle_next     = handle_reg;
        tag_next        = tag_reg;
        delay_next      = delay_reg;
        now_next        = now_reg;
        active_next     = active_reg;
        scan_next       = scan_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_slot_next   = hit_slot_reg;
        out_vld_next    = out_vld_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_fired_next  = out_fired_reg;
        out_handle_next = out_handle_reg;
        out_tag_next    = out_tag_reg;
        out_rem_next    = out_rem_reg;
        ram_we          = 1'b0;
        ram_wslot       = hit_slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                chk_vld_next = 1'b0;
                if (s_axis_tvalid)
                begin
                    mode_next    = mode_t'(s_axis_tuser);
                    handle_next  = s_axis_tdata[HANDLE_W-1:0];
                    tag_next     = s_axis_tdata[HANDLE_W +: TAG_W];
                    delay_next   = s_axis_tdata[HANDLE_W + TAG_W +: DELAY_W];
                    scan_next    = '0;
                    hit_next     = 1'b0;
                    if (mode_t'(s_axis_tuser) inside {MODE_ADD, MODE_REMOVE, MODE_RESET,
                                                      MODE_QUERY, MODE_SERVICE})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_SCAN:
            begin
                // The read for each slot is issued in the cycle before that slot is checked.
                if (scan_reg < CNT_W'(SLOT_COUNT))
                begin
                    scan_next    = scan_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = scan_reg[IDX_W-1:0];
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg && slot_match)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = chk_idx_reg;
                    hit_slot_next = rd_slot;
                    state_next    = ST_APPLY;
                end
                else if (chk_vld_reg && (chk_idx_reg == IDX_W'(SLOT_COUNT - 1)))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = STAT_DONE;
                    out_fired_next  = 1'b0;
                    out_handle_next = '0;
                    out_tag_next    = '0;
                    out_rem_next    = '0;
                    state_next      = ST_IDLE;
                    case (mode_reg)
                        MODE_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        MODE_ADD:
                        begin
                            if (hit_reg)
                            begin
                                ram_we                   = 1'b1;
                                ram_wslot.handle         = handle_reg;
                                ram_wslot.tag            = tag_reg;
                                ram_wslot.deadline       = new_deadline;
                                active_next[hit_idx_reg] = 1'b1;
                            end
                            else
                            begin
                                out_status_next = STAT_FULL;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                active_next[hit_idx_reg] = 1'b0;
                            end
                            else
                            begin
                                out_status_next = STAT_NOMATCH;
                            end
                        end
                        MODE_RESET:
                        begin
                            if (hit_reg)
                            begin
                                ram_we             = 1'b1;
                                ram_wslot.deadline = new_deadline;
                            end
                            else
                            begin
                                out_status_next = STAT_NOMATCH;
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (!hit_reg)
                            begin
                                out_status_next = STAT_NOMATCH;
                            end
                            else if (hit_slot_reg.deadline > now_reg)
                            begin
                                out_rem_next = REM_W'(hit_slot_reg.deadline - now_reg);
                            end
                        end
                        MODE_SERVICE:
                        begin
                            if (hit_reg)
                            begin
                                out_fired_next           = 1'b1;
                                out_handle_next          = hit_slot_reg.handle;
                                out_tag_next             = hit_slot_reg.tag;
                                active_next[hit_idx_reg] = 1'b0;
                            end
                            else
                            begin
                                out_status_next = STAT_NOMATCH;
                            end
                        end
                        default:
                        begin
                            out_status_next = STAT_DONE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            active_reg  <= '0;
            scan_reg    <= '0;
            chk_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            active_reg  <= active_next;
            scan_reg    <= scan_next;
            chk_vld_reg <= chk_vld_next;
            hit_reg     <= hit_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        handle_reg     <= handle_next;
        tag_reg        <= tag_next;
        delay_reg      <= delay_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_slot_reg   <= hit_slot_next;
        out_status_reg <= out_status_next;
        out_fired_reg  <= out_fired_next;
        out_handle_reg <= out_handle_next;
        out_tag_reg    <= out_tag_next;
        out_rem_reg    <= out_rem_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_rem_reg, out_tag_reg, out_handle_reg};
    assign m_axis_tuser  = {out_fired_reg, out_status_reg};

    // An add only ever claims a slot that is free.
    a_add_claims_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && mode_reg == MODE_ADD && hit_reg)
        |-> !active_reg[hit_idx_reg])
        else $error("add claimed a slot that is already active");

    // Remove, reset, query and service only act on an active slot.
    a_hit_is_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && hit_reg && mode_reg != MODE_ADD)
        |-> active_reg[hit_idx_reg])
        else $error("matched slot is not active");

    // A fired word always reports success.
    a_fired_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_fired_reg) |-> (out_status_reg == STAT_DONE))
        else $error("fired result without done status");

    // The tick counter moves only when a tick command completes.
    a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        (now_reg != $past(now_reg))
        |-> ($past(state_reg) == ST_APPLY && $past(mode_reg) == MODE_TICK))
        else $error("tick counter changed outside a tick command");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the callout timer table: directed commands, then random traffic.
`timescale 1ns / 1ps

module tb;
    import ctt_pkg::*;

    // Modes 6 and 7 are not part of the command set; the block must answer them with zeros.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_TAIL   = 200;
    localparam int SEGMENT_LEN  = 80;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT + 3);
    localparam int STALL_LIMIT  = 4000;
    localparam int HANDLE_POOL  = 12;

    // Mode weights per traffic segment, in the order tick, add, remove, reset, query, service.
    // The segments fill the table, drain it, mix everything, and spread handles widely.
    localparam int MODE_WEIGHT [4][6] = '{
        '{ 5, 75,  5,  5,  5,  5},
        '{40,  3, 10,  5, 12, 30},
        '{20, 20, 15, 10, 15, 20},
        '{15, 25, 15, 15, 15, 15}
    };

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    tag;
        logic [DELAY_W-1:0]  delay;
    } timer_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                fired;
        logic [HANDLE_W-1:0] fired_handle;
        logic [TAG_W-1:0]    fired_tag;
        logic [REM_W-1:0]    remaining;
    } timer_reply_t;

    typedef struct packed {
        timer_cmd_t   cmd;
        logic         known;
        timer_reply_t reply;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [MODE_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // Shadow copy of the timer table.
    logic [TICK_BITS-1:0] now_tick;
    logic                 slot_busy  [SLOT_COUNT];
    logic [TICK_BITS-1:0] slot_due   [SLOT_COUNT];
    logic [HANDLE_W-1:0]  slot_owner [SLOT_COUNT];
    logic [TAG_W-1:0]     slot_token [SLOT_COUNT];

    timer_reply_t  pending_replies [$];
    directed_row_t directed_rows [$];
    int            mismatch_count = 0;
    bit            quiet_tail = 1'b0;
    bit            hold_request = 1'b0;

    callout_timer_table_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one command to the shadow table and returns the reply it should produce.
    function automatic timer_reply_t predict_timer_reply(timer_cmd_t c);
        timer_reply_t r;
        int           hit;
        r = '0;
        hit = -1;
        case (c.mode)
            MODE_TICK:
                now_tick = now_tick + 1'b1;
            MODE_ADD:
            begin
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    if (!slot_busy[i])
                        hit = i;
                if (hit < 0)
                    r.status = STAT_FULL;
                else
                begin
                    slot_busy[hit]  = 1'b1;
                    slot_owner[hit] = c.handle;
                    slot_token[hit] = c.tag;
                    slot_due[hit]   = now_tick + c.delay;
                end
            end
            MODE_REMOVE, MODE_RESET, MODE_QUERY:
            begin
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    if (slot_busy[i] && slot_owner[i] == c.handle)
                        hit = i;
                if (hit < 0)
                    r.status = STAT_NOMATCH;
                else if (c.mode == MODE_REMOVE)
                    slot_busy[hit] = 1'b0;
                else if (c.mode == MODE_RESET)
                    slot_due[hit] = now_tick + c.delay;
                else if (slot_due[hit] > now_tick)
                    r.remaining = slot_due[hit] - now_tick;
            end
            MODE_SERVICE:
            begin
                // A deadline that wrapped to zero never counts as expired.
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    if (slot_busy[i] && slot_due[i] != '0 && now_tick >= slot_due[i])
                        hit = i;
                if (hit < 0)
                    r.status = STAT_NOMATCH;
                else
                begin
                    r.fired        = 1'b1;
                    r.fired_handle = slot_owner[hit];
                    r.fired_tag    = slot_token[hit];
                    slot_busy[hit] = 1'b0;
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic directed_row_t directed_row(
        logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] handle, logic [TAG_W-1:0] tag,
        logic [DELAY_W-1:0] delay, logic known = 1'b0, logic [STATUS_W-1:0] status = STAT_DONE);
        directed_row_t row;
        row.cmd   = '{mode, handle, tag, delay};
        row.known = known;
        row.reply = '0;
        row.reply.status = status;
        return row;
    endfunction

    function automatic timer_cmd_t random_command(int index);
        timer_cmd_t c;
        int         segment;
        int         pick;
        segment = (index / SEGMENT_LEN) % 4;
        c.mode = MODE_TICK;
        if ($urandom_range(0, 99) < 3)
            c.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
        else
        begin
            pick = $urandom_range(0, 99);
            for (int k = 0; k < 6; k++)
            begin
                if (pick >= 0 && pick < MODE_WEIGHT[segment][k])
                    c.mode = k[MODE_W-1:0];
                pick -= MODE_WEIGHT[segment][k];
            end
        end
        // Handles mostly come from a small pool so that remove, reset and query find matches.
        if ($urandom_range(0, 99) < ((segment == 3) ? 60 : 25))
            c.handle = HANDLE_W'($urandom_range(0, 16'hFFFF));
        else
            c.handle = HANDLE_W'($urandom_range(0, HANDLE_POOL - 1));
        c.tag = TAG_W'($urandom_range(0, 16'hFFFF));
        pick = $urandom_range(0, 99);
        if (pick < 65)
            c.delay = $urandom_range(0, 40);
        else if (pick < 80)
            c.delay = $urandom();
        else if (pick < 93)
            c.delay = 32'hFFFF_FFFF - $urandom_range(0, 60);
        else
            c.delay = '0 - now_tick;
        return c;
    endfunction

    task automatic issue_command(input timer_cmd_t c, input logic known, input timer_reply_t typed);
        timer_reply_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c.delay, c.tag, c.handle};
        s_axis_tuser  <= c.mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_timer_reply(c);
        pending_replies.push_back(known ? typed : predicted);
    endtask

    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Receiver: random stall bursts, one long hold-off that backs up the block, then no stalls.
    initial
    begin : receiver
        int run;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : reply_check
        timer_reply_t got;
        timer_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status       = m_axis_tuser[STATUS_W-1:0];
            got.fired        = m_axis_tuser[STATUS_W];
            got.fired_handle = m_axis_tdata[HANDLE_W-1:0];
            got.fired_tag    = m_axis_tdata[HANDLE_W +: TAG_W];
            got.remaining    = m_axis_tdata[HANDLE_W + TAG_W +: REM_W];
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: reply word with nothing outstanding: %p", $realtime, got);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.status != want.status || got.fired != want.fired ||
                    got.fired_handle != want.fired_handle || got.fired_tag != want.fired_tag ||
                    got.remaining != want.remaining)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: reply mismatch, expected %p, got %p",
                                 $realtime, want, got);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        timer_cmd_t c;
        now_tick = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_busy[i]  = 1'b0;
            slot_due[i]   = '0;
            slot_owner[i] = '0;
            slot_token[i] = '0;
        end

        // Error answers on an empty table, tick, and the spare modes with every bit set.
        directed_rows.push_back(directed_row(MODE_QUERY,    16'h0000, 16'h0000, 32'h0, 1'b1,
                                             STAT_NOMATCH));
        directed_rows.push_back(directed_row(MODE_REMOVE,   16'hFFFF, 16'h0000, 32'h0, 1'b1,
                                             STAT_NOMATCH));
        directed_rows.push_back(directed_row(MODE_RESET,    16'h1234, 16'h0000, 32'h5, 1'b1,
                                             STAT_NOMATCH));
        directed_rows.push_back(directed_row(MODE_SERVICE,  16'h0000, 16'h0000, 32'h0, 1'b1,
                                             STAT_NOMATCH));
        directed_rows.push_back(directed_row(MODE_TICK,     16'h0000, 16'h0000, 32'h0, 1'b1,
                                             STAT_DONE));
        directed_rows.push_back(directed_row(MODE_SPARE_LO, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                             1'b1, STAT_DONE));
        directed_rows.push_back(directed_row(MODE_SPARE_HI, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                             1'b1, STAT_DONE));
        // The first add wraps its deadline to zero, so that slot must never fire.
        directed_rows.push_back(directed_row(MODE_ADD,     16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        directed_rows.push_back(directed_row(MODE_ADD,     16'h0000, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_QUERY,   16'hFFFF, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_QUERY,   16'h0000, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_SERVICE, 16'h0000, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_SERVICE, 16'h0000, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_ADD,     16'h00AA, 16'h5A5A, 32'h3));
        directed_rows.push_back(directed_row(MODE_QUERY,   16'h00AA, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_RESET,   16'h00AA, 16'h0000, 32'h1));
        directed_rows.push_back(directed_row(MODE_ADD,     16'h00AA, 16'h1111, 32'h0));
        directed_rows.push_back(directed_row(MODE_TICK,    16'h0000, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_SERVICE, 16'h0000, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_SERVICE, 16'h0000, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_REMOVE,  16'hFFFF, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_QUERY,   16'hFFFF, 16'h0000, 32'h0));
        directed_rows.push_back(directed_row(MODE_ADD,     16'h0BEE, 16'h8001, 32'hFFFF_FFF0));
        directed_rows.push_back(directed_row(MODE_QUERY,   16'h0BEE, 16'h0000, 32'h0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            sender_gap();
            issue_command(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].reply);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_AT)
                hold_request = 1'b1;
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                quiet_tail = 1'b1;
            sender_gap();
            c = random_command(i);
            issue_command(c, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ctt_pkg.sv
hdl/ctt_ram.sv
hdl/callout_timer_table_unit.sv
bench/tb.sv
